### rtl/sae_pkg.sv
// shared types and constants for the sponge aead engine
package sae_pkg;

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_AD      = 2'd1;
	localparam logic [1:0] ACT_PAYLOAD = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [1:0] REG_DECRYPT  = 2'd2;

	localparam int unsigned INIT_ROUNDS = 12;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_AD      = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ENG_IDLE  = 2'd0,
		ENG_PERM  = 2'd1,
		ENG_EMIT  = 2'd2
	} eng_state_t;

	// command from the front part to the back part
	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] word_high;
		logic [63:0] word_low;
		logic [4:0]  byte_count;
		logic [63:0] expected_tag_high;
		logic [63:0] expected_tag_low;
	} cmd_t;

	typedef struct packed {
		logic [63:0] out_high;
		logic [63:0] out_low;
		logic [4:0]  out_bytes;
		logic        is_final;
		logic [63:0] tag_high;
		logic [63:0] tag_low;
		logic        tag_match;
		logic        status;
	} res_t;

	function automatic logic [7:0] round_const(input logic [3:0] r);
		logic [7:0] c;
		begin
			unique case (r)
				4'd0: c = 8'hf0;
				4'd1: c = 8'he1;
				4'd2: c = 8'hd2;
				4'd3: c = 8'hc3;
				4'd4: c = 8'hb4;
				4'd5: c = 8'ha5;
				4'd6: c = 8'h96;
				4'd7: c = 8'h87;
				4'd8: c = 8'h78;
				4'd9: c = 8'h69;
				4'd10: c = 8'h5a;
				4'd11: c = 8'h4b;
				default: c = 8'h00;
			endcase
			return c;
		end
	endfunction

	function automatic logic [319:0] perm_round(input logic [319:0] s, input logic [3:0] r);
		logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
		begin
			x0 = s[319:256]; x1 = s[255:192]; x2 = s[191:128]; x3 = s[127:64]; x4 = s[63:0];
			x2 = x2 ^ {56'd0, round_const(r)};
			x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
			t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
			x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
			x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
			x0 = x0 ^ {x0[18:0], x0[63:19]} ^ {x0[27:0], x0[63:28]};
			x1 = x1 ^ {x1[60:0], x1[63:61]} ^ {x1[38:0], x1[63:39]};
			x2 = x2 ^ {x2[0], x2[63:1]} ^ {x2[5:0], x2[63:6]};
			x3 = x3 ^ {x3[9:0], x3[63:10]} ^ {x3[16:0], x3[63:17]};
			x4 = x4 ^ {x4[6:0], x4[63:7]} ^ {x4[40:0], x4[63:41]};
			return {x0, x1, x2, x3, x4};
		end
	endfunction

endpackage

### rtl/sae_front.sv
// input queue: accepts items and holds them for the engine
module sae_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  sae_pkg::cmd_t cmd_in,
	output logic          cmd_valid,
	input  logic          cmd_take,
	output sae_pkg::cmd_t cmd_out
);
	sae_pkg::cmd_t mem_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd_out   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (cmd_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cmd_take);
		end
	end
endmodule

### rtl/sae_engine.sv
// sponge state, round unit and sequencer
module sae_engine #(
	parameter int unsigned RATE_BYTES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [63:0]   key_high,
	input  logic [63:0]   key_low,
	input  logic          decrypt_mode,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  sae_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_take,
	output sae_pkg::res_t res
);
	localparam int unsigned RATE_EFF = (RATE_BYTES > 16) ? 16 : ((RATE_BYTES < 8) ? 8 : RATE_BYTES);
	localparam int unsigned BLOCK_ROUNDS = (RATE_EFF <= 8) ? 6 : 8;
	localparam logic [63:0] IV = {8'd128, 8'(RATE_EFF * 8), 8'd12, 8'(BLOCK_ROUNDS), 32'd0};
	localparam logic [4:0] RATE_N = 5'(RATE_EFF);
	localparam bit KEY_HI = RATE_EFF >= 16;

	sae_pkg::eng_state_t st_q, st_d;
	sae_pkg::phase_t     phase_q, phase_d;
	logic                sep_q, sep_d;
	logic [319:0]        s_q, s_d;
	logic [3:0]          rnd_q, rnd_d;
	logic                fin_q, fin_d;      // finalization permute pending
	logic                flip_q, flip_d;    // domain flip after permute
	logic [127:0]        etag_q, etag_d;
	logic                dec_q, dec_d;
	sae_pkg::res_t       res_q, res_d;
	logic                rv_q, rv_d;

	logic [4:0]   n;
	logic         full_blk;
	logic [127:0] m, din, pad, kx;
	logic [319:0] s_x, s_k;
	logic [63:0]  o_hi, o_lo;

	always_comb begin
		n = (cmd.byte_count > RATE_N) ? RATE_N : cmd.byte_count;
		full_blk = n >= RATE_N;
		for (int b = 0; b < 16; b++) begin
			m[127 - 8*b -: 8] = (5'(b) < n) ? 8'hff : 8'h00;
			pad[127 - 8*b -: 8] = (5'(b) == n) ? sae_pkg::PAD_BYTE : 8'h00;
		end
		if (full_blk) pad = '0;
		din = {cmd.word_high, cmd.word_low} & m;
	end

	assign res_valid = rv_q;
	assign res = res_q;

	always_comb begin
		st_d = st_q; phase_d = phase_q; sep_d = sep_q; s_d = s_q; rnd_d = rnd_q;
		fin_d = fin_q; flip_d = flip_q; etag_d = etag_q; dec_d = dec_q;
		res_d = res_q; rv_d = rv_q; cmd_take = 1'b0;
		s_x = s_q; s_k = s_q; o_hi = '0; o_lo = '0; kx = '0;
		if (res_take) rv_d = 1'b0;
		unique case (st_q)
			sae_pkg::ENG_IDLE: begin
				if (cmd_valid && (!rv_q || res_take)) begin
					cmd_take = 1'b1;
					res_d = '0;
					priority if (cmd.action == sae_pkg::ACT_START) begin
						s_d = {IV, key_high, key_low, cmd.word_high, cmd.word_low};
						rnd_d = 4'd0; fin_d = 1'b1; flip_d = 1'b0;
						phase_d = sae_pkg::PH_AD; sep_d = 1'b0;
						st_d = sae_pkg::ENG_PERM;
					end else if (cmd.action == sae_pkg::ACT_AD) begin
						if (phase_q != sae_pkg::PH_AD || sep_q) begin
							res_d.status = 1'b1; rv_d = 1'b1;
						end else begin
							s_d[319:192] = s_q[319:192] ^ din ^ pad;
							rnd_d = 4'(12 - BLOCK_ROUNDS); fin_d = 1'b0;
							flip_d = !full_blk;
							if (!full_blk) sep_d = 1'b1;
							st_d = sae_pkg::ENG_PERM;
						end
					end else if (cmd.action == sae_pkg::ACT_PAYLOAD) begin
						if (phase_q == sae_pkg::PH_IDLE) begin
							res_d.status = 1'b1; rv_d = 1'b1;
						end else begin
							s_x[0] = s_q[0] ^ !sep_q;
							sep_d = 1'b1;
							if (decrypt_mode) begin
								{o_hi, o_lo} = (s_x[319:192] ^ {cmd.word_high, cmd.word_low}) & m;
								s_x[319:192] = (s_x[319:192] & ~m) | din;
							end else begin
								s_x[319:192] = s_x[319:192] ^ din;
								{o_hi, o_lo} = s_x[319:192] & m;
							end
							res_d.out_high = o_hi; res_d.out_low = o_lo;
							res_d.out_bytes = n;
							flip_d = 1'b0;
							if (full_blk) begin
								s_d = s_x; rnd_d = 4'(12 - BLOCK_ROUNDS); fin_d = 1'b0;
								phase_d = sae_pkg::PH_PAYLOAD;
								dec_d = 1'b0;
								st_d = sae_pkg::ENG_PERM;
							end else begin
								s_k = s_x;
								s_k[319:192] = s_x[319:192] ^ pad;
								kx = {key_high, key_low};
								if (KEY_HI) s_k[191:64] = s_k[191:64] ^ kx;
								else s_k[255:128] = s_k[255:128] ^ kx;
								s_d = s_k; rnd_d = 4'd0; fin_d = 1'b1;
								etag_d = {cmd.expected_tag_high, cmd.expected_tag_low};
								dec_d = decrypt_mode;
								res_d.is_final = 1'b1;
								phase_d = sae_pkg::PH_IDLE; sep_d = 1'b0;
								st_d = sae_pkg::ENG_PERM;
							end
							rv_d = 1'b0;
						end
					end else begin
						res_d.status = 1'b1; rv_d = 1'b1;
					end
				end
			end
			sae_pkg::ENG_PERM: begin
				s_d = sae_pkg::perm_round(s_q, rnd_q);
				rnd_d = rnd_q + 4'd1;
				if (rnd_q == 4'd11) begin
					if (fin_q) s_d[127:0] = s_d[127:0] ^ {key_high, key_low};
					if (flip_q) s_d[0] = ~s_d[0];
					// start item and blocks other than payload produce no output
					st_d = sae_pkg::ENG_IDLE;
					if (res_q.out_bytes != 5'd0 || res_q.is_final ||
					    (res_q.status == 1'b0 && !fin_q && res_q.out_high == '0 && 1'b0)) begin
						rv_d = 1'b1;
					end
					if (res_q.is_final) begin
						res_d.tag_high = s_d[127:64]; res_d.tag_low = s_d[63:0];
						res_d.tag_match = dec_q && (s_d[127:0] == etag_q);
					end
				end
			end
			sae_pkg::ENG_EMIT: st_d = sae_pkg::ENG_IDLE;
			default: st_d = sae_pkg::ENG_IDLE;
		endcase
	end

	// payload result flag kept apart so a zero-byte payload still reports
	logic pay_q, pay_d;
	always_comb begin
		pay_d = pay_q;
		if (st_q == sae_pkg::ENG_IDLE && cmd_take)
			pay_d = cmd.action == sae_pkg::ACT_PAYLOAD && phase_q != sae_pkg::PH_IDLE;
	end

	logic rv_f;
	always_comb begin
		rv_f = rv_d;
		if (st_q == sae_pkg::ENG_PERM && rnd_q == 4'd11) rv_f = pay_q;
	end

	always_ff @(posedge clk) begin
		s_q <= s_d; etag_q <= etag_d; res_q <= res_d; rnd_q <= rnd_d;
		fin_q <= fin_d; flip_q <= flip_d; dec_q <= dec_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sae_pkg::ENG_IDLE; phase_q <= sae_pkg::PH_IDLE; sep_q <= 1'b0;
			rv_q <= 1'b0; pay_q <= 1'b0;
		end else begin
			st_q <= st_d; phase_q <= phase_d; sep_q <= sep_d; rv_q <= rv_f; pay_q <= pay_d;
		end
	end
endmodule

### rtl/sponge_aead_128a_engine.sv
// top level of the sponge aead engine
//  channel | handshake        | payload
//  input   | push / full      | action, word_high, word_low, byte_count, expected tag
//  result  | pop / empty      | out_high, out_low, out_bytes, is_final, tag, tag_match, status
//  config  | cfg_valid/ready  | cfg_index, cfg_data
// one round per cycle: a block runs the last BLOCK_ROUNDS rounds, start
// and final payload run all rounds; rejected items get a status result from idle
// a two-entry input queue takes new transactions while the engine rounds
// a held result stalls the engine; the input queue then fills and raises full
// reset clears the state flags; the sponge words need none
module sponge_aead_128a_engine #(
	parameter int unsigned RATE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [63:0] word_high,
	input  logic [63:0] word_low,
	input  logic [4:0]  byte_count,
	input  logic [63:0] expected_tag_high,
	input  logic [63:0] expected_tag_low,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic [4:0]  out_bytes,
	output logic        is_final,
	output logic [63:0] tag_high,
	output logic [63:0] tag_low,
	output logic        tag_match,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	logic [63:0]   key_high_q, key_low_q;
	logic          dec_q;
	sae_pkg::cmd_t cin, cq;
	sae_pkg::res_t r;
	logic          cv, ct, rv;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0; key_low_q <= '0; dec_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sae_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				sae_pkg::REG_KEY_LOW:  key_low_q <= cfg_data;
				sae_pkg::REG_DECRYPT:  dec_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cin = '{action: action, word_high: word_high, word_low: word_low,
		byte_count: byte_count, expected_tag_high: expected_tag_high,
		expected_tag_low: expected_tag_low};

	sae_front u_front (.clk, .arst_n, .push, .full, .cmd_in(cin),
		.cmd_valid(cv), .cmd_take(ct), .cmd_out(cq));

	sae_engine #(.RATE_BYTES(RATE_BYTES)) u_engine (.clk, .arst_n,
		.key_high(key_high_q), .key_low(key_low_q), .decrypt_mode(dec_q),
		.cmd_valid(cv), .cmd_take(ct), .cmd(cq),
		.res_valid(rv), .res_take(pop && rv), .res(r));

	assign empty     = !rv;
	assign out_high  = r.out_high;
	assign out_low   = r.out_low;
	assign out_bytes = r.out_bytes;
	assign is_final  = r.is_final;
	assign tag_high  = r.tag_high;
	assign tag_low   = r.tag_low;
	assign tag_match = r.tag_match;
	assign status    = r.status;
endmodule

### tb/sae_checker.sv
// checker for the sponge aead engine: watches the channels, predicts results and compares them
`timescale 1ns / 1ps
module sae_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  action,
	input  logic [63:0] word_high,
	input  logic [63:0] word_low,
	input  logic [4:0]  byte_count,
	input  logic [63:0] expected_tag_high,
	input  logic [63:0] expected_tag_low,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] out_high,
	input  logic [63:0] out_low,
	input  logic [4:0]  out_bytes,
	input  logic        is_final,
	input  logic [63:0] tag_high,
	input  logic [63:0] tag_low,
	input  logic        tag_match,
	input  logic        status,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending_count
);

	localparam logic [63:0] AEAD_IV = 64'h80800c0800000000;

	logic [63:0]      sw [5];
	sae_pkg::phase_t  ph;
	logic             sep_done;
	logic [63:0]      key_hi, key_lo;
	logic             dec_mode;
	sae_pkg::res_t    expected_results [$];

	function automatic logic [63:0] ror(input logic [63:0] v, input int r);
		return (v >> r) | (v << (64 - r));
	endfunction

	task automatic sponge_rounds(input int rounds);
		logic [63:0] t0, t1, t2, t3, t4;
		logic [7:0]  rc [12];
		rc = '{8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5, 8'h96, 8'h87,
			8'h78, 8'h69, 8'h5a, 8'h4b};
		for (int r = 12 - rounds; r < 12; r++) begin
			sw[2] ^= {56'd0, rc[r]};
			sw[0] ^= sw[4]; sw[4] ^= sw[3]; sw[2] ^= sw[1];
			t0 = ~sw[0] & sw[1]; t1 = ~sw[1] & sw[2]; t2 = ~sw[2] & sw[3];
			t3 = ~sw[3] & sw[4]; t4 = ~sw[4] & sw[0];
			sw[0] ^= t1; sw[1] ^= t2; sw[2] ^= t3; sw[3] ^= t4; sw[4] ^= t0;
			sw[1] ^= sw[0]; sw[0] ^= sw[4]; sw[3] ^= sw[2]; sw[2] = ~sw[2];
			sw[0] ^= ror(sw[0], 19) ^ ror(sw[0], 28);
			sw[1] ^= ror(sw[1], 61) ^ ror(sw[1], 39);
			sw[2] ^= ror(sw[2], 1) ^ ror(sw[2], 6);
			sw[3] ^= ror(sw[3], 10) ^ ror(sw[3], 17);
			sw[4] ^= ror(sw[4], 7) ^ ror(sw[4], 41);
		end
	endtask

	// byte masks for the first k bytes of the block
	function automatic logic [127:0] byte_mask(input int k);
		return (k == 0) ? 128'd0 : ~128'd0 << (128 - 8 * k);
	endfunction

	task automatic pad_block(input int k);
		logic [127:0] p;
		p = 128'h80 << (120 - 8 * k);
		sw[0] ^= p[127:64];
		sw[1] ^= p[63:0];
	endtask

	task automatic absorb_transaction();
		sae_pkg::res_t res;
		int            k;
		logic          whole;
		logic [127:0]  m, d, rate;
		res = '0;
		k = (byte_count > 16) ? 16 : byte_count;
		whole = (k == 16);
		m = byte_mask(k);
		d = {word_high, word_low};
		case (action)
			sae_pkg::ACT_START: begin
				sw[0] = AEAD_IV; sw[1] = key_hi; sw[2] = key_lo;
				sw[3] = word_high; sw[4] = word_low;
				sponge_rounds(sae_pkg::INIT_ROUNDS);
				sw[3] ^= key_hi; sw[4] ^= key_lo;
				ph = sae_pkg::PH_AD;
				sep_done = 1'b0;
				return;
			end
			sae_pkg::ACT_AD: begin
				if (ph != sae_pkg::PH_AD || sep_done) begin
					res.status = 1'b1;
				end else begin
					sw[0] ^= d[127:64] & m[127:64];
					sw[1] ^= d[63:0] & m[63:0];
					if (!whole) pad_block(k);
					sponge_rounds(8);
					if (!whole) begin
						sw[4] ^= 64'd1;
						sep_done = 1'b1;
					end
					return;
				end
			end
			sae_pkg::ACT_PAYLOAD: begin
				if (ph == sae_pkg::PH_IDLE) begin
					res.status = 1'b1;
				end else begin
					if (!sep_done) begin
						sw[4] ^= 64'd1;
						sep_done = 1'b1;
					end
					rate = {sw[0], sw[1]};
					if (dec_mode) begin
						{res.out_high, res.out_low} = (rate ^ d) & m;
						rate = (rate & ~m) | (d & m);
					end else begin
						rate ^= d & m;
						{res.out_high, res.out_low} = rate & m;
					end
					sw[0] = rate[127:64];
					sw[1] = rate[63:0];
					res.out_bytes = 5'(k);
					if (whole) begin
						sponge_rounds(8);
						ph = sae_pkg::PH_PAYLOAD;
					end else begin
						pad_block(k);
						sw[2] ^= key_hi; sw[3] ^= key_lo;
						sponge_rounds(sae_pkg::INIT_ROUNDS);
						sw[3] ^= key_hi; sw[4] ^= key_lo;
						res.is_final = 1'b1;
						res.tag_high = sw[3];
						res.tag_low = sw[4];
						if (dec_mode)
							res.tag_match = (sw[3] == expected_tag_high) &&
								(sw[4] == expected_tag_low);
						ph = sae_pkg::PH_IDLE;
						sep_done = 1'b0;
					end
				end
			end
			default: res.status = 1'b1;
		endcase
		expected_results.push_back(res);
	endtask

	task automatic compare_result();
		sae_pkg::res_t got, want;
		got = '{out_high, out_low, out_bytes, is_final, tag_high, tag_low, tag_match, status};
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			fail_count++;
			return;
		end
		want = expected_results.pop_front();
		if (got !== want) begin
			$display("%0t: result mismatch expected %h actual %h", $time, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) sw[i] = '0;
			ph = sae_pkg::PH_IDLE;
			sep_done = 1'b0;
			key_hi = '0; key_lo = '0; dec_mode = 1'b0;
			expected_results.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (pop && !empty) compare_result();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sae_pkg::REG_KEY_HIGH: key_hi = cfg_data;
					sae_pkg::REG_KEY_LOW:  key_lo = cfg_data;
					sae_pkg::REG_DECRYPT:  dec_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full) absorb_transaction();
			pending_count = expected_results.size();
		end
	end

endmodule

### tb/tb.sv
// top of the sponge aead engine testbench: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb;
	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam int IDLE_LIMIT = 20000;

	logic        clk, arst_n;
	logic        push, full, empty, pop;
	logic [1:0]  action;
	logic [63:0] word_high, word_low, expected_tag_high, expected_tag_low;
	logic [4:0]  byte_count;
	logic [63:0] out_high, out_low, tag_high, tag_low;
	logic [4:0]  out_bytes;
	logic        is_final, tag_match, status;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count, pending_count;
	int          send_idle_pct, recv_idle_pct;
	int          quiet_cycles;

	sponge_aead_128a_engine i_dut (.*);

	sae_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random pop, receiver idles a set share of cycles
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("sponge_aead_128a_engine regression: fail");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// send one transaction, with a random gap before it; push stays high
	// after acceptance until the next gap or the caller drops it
	task automatic send_item(input logic [1:0] act, input logic [63:0] hi, input logic [63:0] lo,
			input logic [4:0] n, input logic [63:0] thi, input logic [63:0] tlo);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		action <= act; word_high <= hi; word_low <= lo;
		byte_count <= n; expected_tag_high <= thi; expected_tag_low <= tlo;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_random(input logic [1:0] act, input int n);
		send_item(act, rand64(), rand64(), 5'(n), rand64(), rand64());
	endtask

	// wait for results to drain plus the longest internal latency, then write
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		push <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int rand_count();
		int c;
		c = $urandom_range(99);
		if (c < 45) return 16;
		if (c < 95) return $urandom_range(15);
		return $urandom_range(31, 17);
	endfunction

	// well-formed message: start, some ad, payload ending in a short block
	task automatic send_message();
		int n_ad, n_pl;
		n_ad = $urandom_range(3);
		n_pl = $urandom_range(3);
		send_random(sae_pkg::ACT_START, 16);
		for (int i = 0; i < n_ad; i++) send_random(sae_pkg::ACT_AD, 16);
		if ($urandom_range(1)) send_random(sae_pkg::ACT_AD, $urandom_range(15));
		for (int i = 0; i < n_pl; i++) send_random(sae_pkg::ACT_PAYLOAD, 16);
		send_random(sae_pkg::ACT_PAYLOAD, $urandom_range(15));
	endtask

	task automatic random_phase(input int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(99) < 80) begin
				send_message();
				sent += 5;
			end else begin
				send_random(2'($urandom_range(3)), rand_count());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0; pop = 1'b0; cfg_valid = 1'b0;
		action = sae_pkg::ACT_START; word_high = '0; word_low = '0; byte_count = '0;
		expected_tag_high = '0; expected_tag_low = '0;
		cfg_index = sae_pkg::REG_KEY_HIGH; cfg_data = '0;
		send_idle_pct = 9; recv_idle_pct = 66;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: out-of-order items in idle, then edge byte counts
		send_random(sae_pkg::ACT_PAYLOAD, 16);
		send_random(sae_pkg::ACT_AD, 4);
		send_random(ACT_UNUSED, 16);
		send_item(sae_pkg::ACT_START, '0, '0, 5'd0, '0, '0);
		send_item(sae_pkg::ACT_PAYLOAD, '1, '1, 5'd16, '0, '0);
		send_item(sae_pkg::ACT_PAYLOAD, '1, '1, 5'd0, '0, '0);
		send_item(sae_pkg::ACT_START, '1, '1, 5'd31, '1, '1);
		send_random(sae_pkg::ACT_AD, 31);
		send_random(sae_pkg::ACT_AD, 8);
		send_random(sae_pkg::ACT_AD, 1);
		send_random(sae_pkg::ACT_PAYLOAD, 9);
		send_random(sae_pkg::ACT_PAYLOAD, 16);
		send_random(sae_pkg::ACT_START, 16);
		send_random(sae_pkg::ACT_START, 16);
		send_random(sae_pkg::ACT_PAYLOAD, 15);

		write_reg(sae_pkg::REG_KEY_HIGH, '1);
		write_reg(sae_pkg::REG_KEY_LOW, '1);
		write_reg(sae_pkg::REG_DECRYPT, 64'd1);
		send_random(sae_pkg::ACT_START, 16);
		send_random(sae_pkg::ACT_PAYLOAD, 16);
		send_random(sae_pkg::ACT_PAYLOAD, 7);
		send_random(sae_pkg::ACT_START, 16);
		send_random(sae_pkg::ACT_PAYLOAD, 0);
		random_phase(200);

		write_reg(sae_pkg::REG_KEY_HIGH, rand64());
		write_reg(sae_pkg::REG_KEY_LOW, rand64());
		write_reg(sae_pkg::REG_DECRYPT, 64'd0);
		random_phase(350);

		send_idle_pct = 66; recv_idle_pct = 9;
		write_reg(sae_pkg::REG_DECRYPT, 64'd1);
		write_reg(sae_pkg::REG_KEY_HIGH, '0);
		write_reg(sae_pkg::REG_KEY_LOW, rand64());
		random_phase(500);

		send_idle_pct = 0; recv_idle_pct = 0;
		write_reg(sae_pkg::REG_DECRYPT, 64'd0);
		write_reg(sae_pkg::REG_KEY_LOW, '0);
		random_phase(500);

		push <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("sponge_aead_128a_engine regression: pass");
		else
			$display("sponge_aead_128a_engine regression: fail");
		$finish;
	end

endmodule
